@@ design/neural_activation_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the activation unit
// Short forms for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef NEURAL_ACTIVATION_UNIT_MACROS_SVH
`define NEURAL_ACTIVATION_UNIT_MACROS_SVH

// check the consequent in the same cycle
`define NAU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check the consequent in the next cycle
`define NAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/nau_pkg.sv @@
// ----------------------------------------------------------------------------
// Activation unit package
// Formats, codes, the pipeline item record and shared Q30 arithmetic.
// ----------------------------------------------------------------------------
package nau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 11;
    localparam int Q_BITS     = 30;

    localparam int TAYLOR_TERMS = 14;
    localparam int POW_STEPS    = 31;
    localparam int DIV_STEPS    = 31;
    localparam int LN_TERMS     = 12;

    localparam logic [2:0] FN_IDENTITY = 3'd0;
    localparam logic [2:0] FN_STEP     = 3'd1;
    localparam logic [2:0] FN_SIGMOID  = 3'd2;
    localparam logic [2:0] FN_TANH     = 3'd3;
    localparam logic [2:0] FN_RELU     = 3'd4;
    localparam logic [2:0] FN_SOFTPLUS = 3'd5;

    localparam logic [1:0] REG_FUNCTION_KIND   = 2'd0;
    localparam logic [1:0] REG_DERIVATIVE_MODE = 2'd1;

    localparam logic [30:0] Q_ONE  = 31'h4000_0000;
    localparam logic [62:0] Q_HALF = 63'h2000_0000;
    localparam logic [30:0] EXP_M1 = 31'd395007542;

    localparam logic [31:0] RECIP_NUM = 32'h8000_0000;
    localparam logic [31:0] RECIP_TBL [0:31] = '{
        32'd0,
        RECIP_NUM / 32'd1,  RECIP_NUM / 32'd2,  RECIP_NUM / 32'd3,  RECIP_NUM / 32'd4,
        RECIP_NUM / 32'd5,  RECIP_NUM / 32'd6,  RECIP_NUM / 32'd7,  RECIP_NUM / 32'd8,
        RECIP_NUM / 32'd9,  RECIP_NUM / 32'd10, RECIP_NUM / 32'd11, RECIP_NUM / 32'd12,
        RECIP_NUM / 32'd13, RECIP_NUM / 32'd14, RECIP_NUM / 32'd15, RECIP_NUM / 32'd16,
        RECIP_NUM / 32'd17, RECIP_NUM / 32'd18, RECIP_NUM / 32'd19, RECIP_NUM / 32'd20,
        RECIP_NUM / 32'd21, RECIP_NUM / 32'd22, RECIP_NUM / 32'd23, RECIP_NUM / 32'd24,
        RECIP_NUM / 32'd25, RECIP_NUM / 32'd26, RECIP_NUM / 32'd27, RECIP_NUM / 32'd28,
        RECIP_NUM / 32'd29, RECIP_NUM / 32'd30, RECIP_NUM / 32'd31
    };

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic                         neg;
        logic                         zero;
        logic [4:0]                   n;
        logic [29:0]                  f;
        logic [30:0]                  term;
        logic signed [32:0]           sum;
        logic [30:0]                  r;
        logic [31:0]                  den;
        logic [30:0]                  dlo;
        logic [32:0]                  rem;
        logic [30:0]                  quo;
        logic [30:0]                  q1;
        logic [30:0]                  sq;
        logic [30:0]                  lp;
        logic [30:0]                  ls;
    } tok_t;

    function automatic logic [30:0] mul_q30(input logic [30:0] p, input logic [30:0] q);
        logic [62:0] prod;
        prod = 63'(p) * 63'(q) + Q_HALF;
        return prod[60:30];
    endfunction

    function automatic logic [30:0] div_small(input logic [30:0] p, input logic [4:0] k);
        logic [62:0] est_full;
        logic [30:0] est;
        logic [35:0] back;
        logic [31:0] rem;
        est_full = 63'(p) * 63'(RECIP_TBL[k]);
        est      = est_full[61:31];
        back     = 36'(est) * 36'(k);
        rem      = 32'(36'(p) - back);
        return (rem >= 32'(k)) ? est + 31'd1 : est;
    endfunction

endpackage

@@ design/nau_taylor_cell.sv @@
// ----------------------------------------------------------------------------
// Exponential series cell
// One term of the Taylor series of exp(-f): multiply, divide by the term index.
// ----------------------------------------------------------------------------
module nau_taylor_cell
    import nau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [4:0] divisor,
    input  logic       up_valid,
    input  tok_t       up_tok,
    output logic       dn_valid,
    output tok_t       dn_tok
);

    logic        va_reg;
    logic        vb_reg;
    tok_t        ta_reg;
    tok_t        ta_next;
    tok_t        tb_reg;
    tok_t        tb_next;
    logic [60:0] prod;
    logic [30:0] quot;

    always_comb
    begin
        prod         = 61'(up_tok.term) * 61'(up_tok.f);
        ta_next      = up_tok;
        ta_next.term = prod[60:30];
    end

    always_comb
    begin
        quot         = div_small(ta_reg.term, divisor);
        tb_next      = ta_reg;
        tb_next.term = quot;
        if (divisor[0])
        begin
            tb_next.sum = ta_reg.sum - $signed({2'b00, quot});
        end
        else
        begin
            tb_next.sum = ta_reg.sum + $signed({2'b00, quot});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (advance)
        begin
            va_reg <= up_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ta_reg <= ta_next;
            tb_reg <= tb_next;
        end
    end

    assign dn_valid = vb_reg;
    assign dn_tok   = tb_reg;

endmodule

@@ design/nau_pow_cell.sv @@
// ----------------------------------------------------------------------------
// Integer power cell
// One rounded multiply by exp(-1), applied when the step is below the count.
// ----------------------------------------------------------------------------
module nau_pow_cell
    import nau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [4:0] step,
    input  logic       up_valid,
    input  tok_t       up_tok,
    output logic       dn_valid,
    output tok_t       dn_tok
);

    logic valid_reg;
    tok_t tok_reg;
    tok_t tok_next;

    always_comb
    begin
        tok_next = up_tok;
        if (up_tok.n > step)
        begin
            tok_next.r = mul_q30(up_tok.r, EXP_M1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_tok   = tok_reg;

endmodule

@@ design/nau_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step of the radix-2 divider: shift in a bit, trial subtract.
// ----------------------------------------------------------------------------
module nau_div_cell
    import nau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  logic up_valid,
    input  tok_t up_tok,
    output logic dn_valid,
    output tok_t dn_tok
);

    logic        valid_reg;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic [32:0] rem_sh;
    logic        ge;

    always_comb
    begin
        rem_sh   = {up_tok.rem[31:0], up_tok.dlo[30]};
        ge       = rem_sh >= {1'b0, up_tok.den};
        tok_next = up_tok;
        tok_next.rem = ge ? rem_sh - {1'b0, up_tok.den} : rem_sh;
        tok_next.dlo = {up_tok.dlo[29:0], 1'b0};
        tok_next.quo = {up_tok.quo[29:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_tok   = tok_reg;

endmodule

@@ design/nau_ln_cell.sv @@
// ----------------------------------------------------------------------------
// Logarithm series cell
// One odd term of the atanh series: raise the power, divide, accumulate.
// ----------------------------------------------------------------------------
module nau_ln_cell
    import nau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [4:0] divisor,
    input  logic       up_valid,
    input  tok_t       up_tok,
    output logic       dn_valid,
    output tok_t       dn_tok
);

    logic va_reg;
    logic vb_reg;
    tok_t ta_reg;
    tok_t ta_next;
    tok_t tb_reg;
    tok_t tb_next;

    always_comb
    begin
        ta_next    = up_tok;
        ta_next.lp = mul_q30(up_tok.lp, up_tok.sq);
    end

    always_comb
    begin
        tb_next    = ta_reg;
        tb_next.ls = ta_reg.ls + div_small(ta_reg.lp, divisor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (advance)
        begin
            va_reg <= up_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ta_reg <= ta_next;
            tb_reg <= tb_next;
        end
    end

    assign dn_valid = vb_reg;
    assign dn_tok   = tb_reg;

endmodule

@@ design/neural_activation_unit.sv @@
// ----------------------------------------------------------------------------
// Neural activation unit
// Takes and returns one item per clock, sustained while the skid register is
// empty. Each item runs through the cell chain in order: one input stage, 28
// stages for the 14-term exponential series, 31 power-of-exp(-1) steps, a setup
// stage, a 31-step radix-2 divider, a second setup stage, a second 31-step
// divider, 24 stages for the 12-term logarithm series and the output register.
// Every item runs through the whole chain whatever the selected function. A
// skid register behind the output lets the chain keep moving while one result
// waits; input stalls only when both output and skid hold a result.
// ----------------------------------------------------------------------------
`include "neural_activation_unit_macros.svh"

module neural_activation_unit
    import nau_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [2:0]                   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] x_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] y_out
);

    localparam int SW = 34;
    localparam logic [35:0]   AQ_MAX = 36'h8_0000_0000;
    localparam logic [33:0]   RND    = 34'd1 << (Q_BITS - 1 - FRAC_BITS);
    localparam logic signed [SW-1:0] ONE_Y  = SW'(1) <<< FRAC_BITS;
    localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (DATA_WIDTH - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic [2:0] kind_reg;
    logic       deriv_reg;
    logic       advance;

    logic       s0_valid_reg;
    tok_t       s0_tok_reg;
    tok_t       s0_tok_next;
    logic       s1_valid_reg;
    tok_t       s1_tok_reg;
    tok_t       s1_tok_next;
    logic       s2_valid_reg;
    tok_t       s2_tok_reg;
    tok_t       s2_tok_next;

    logic [TAYLOR_TERMS:0] tay_valid;
    tok_t                  tay_tok [0:TAYLOR_TERMS];
    logic [POW_STEPS:0]    pow_valid;
    tok_t                  pow_tok [0:POW_STEPS];
    logic [DIV_STEPS:0]    d1_valid;
    tok_t                  d1_tok  [0:DIV_STEPS];
    logic [DIV_STEPS:0]    d2_valid;
    tok_t                  d2_tok  [0:DIV_STEPS];
    logic [LN_TERMS:0]     ln_valid;
    tok_t                  ln_tok  [0:LN_TERMS];

    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic [DATA_WIDTH-1:0] out_y_reg;
    logic [DATA_WIDTH-1:0] skid_y_reg;
    logic [DATA_WIDTH-1:0] final_y;
    logic                  take;
    logic                  pipe_valid;

    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] a_int;
    logic [35:0]           aq;
    logic [36:0]           aq2_full;
    logic [35:0]           aq2;
    logic [35:0]           v;
    logic [30:0]           t_val;
    logic [30:0]           num1;
    logic [30:0]           hi1;
    logic [30:0]           hi2;
    logic signed [SW-1:0]  x_ext;
    logic signed [SW-1:0]  y_full;
    tok_t                  fin;

    function automatic logic signed [SW-1:0] from_q30(input logic [31:0] mag);
        logic [33:0] rounded;
        rounded = (34'(mag) + RND) >> (Q_BITS - FRAC_BITS);
        return $signed(rounded);
    endfunction

    assign advance    = !skid_valid_reg;
    assign in_stall   = skid_valid_reg;
    assign take       = out_valid_reg && !out_stall;
    assign pipe_valid = ln_valid[LN_TERMS];
    assign out_valid  = out_valid_reg;
    assign y_out      = $signed(out_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= FN_IDENTITY;
            deriv_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FUNCTION_KIND:   kind_reg  <= cfg_data;
                REG_DERIVATIVE_MODE: deriv_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        a_mag    = x_in[DATA_WIDTH-1] ? (~x_in + 1'b1) : x_in;
        a_int    = a_mag >> FRAC_BITS;
        aq       = (a_int >= DATA_WIDTH'(32)) ? AQ_MAX
                                              : (36'(a_mag) << (Q_BITS - FRAC_BITS));
        aq2_full = {aq, 1'b0};
        aq2      = (aq2_full > {1'b0, AQ_MAX}) ? AQ_MAX : aq2_full[35:0];
        v        = (kind_reg == FN_TANH) ? aq2 : aq;

        s0_tok_next      = '0;
        s0_tok_next.x    = x_in;
        s0_tok_next.neg  = x_in[DATA_WIDTH-1];
        s0_tok_next.zero = v[35];
        s0_tok_next.n    = v[34:30];
        s0_tok_next.f    = v[29:0];
        s0_tok_next.term = Q_ONE;
        s0_tok_next.sum  = $signed({2'b00, Q_ONE});
    end

    assign tay_valid[0] = s0_valid_reg;
    assign tay_tok[0]   = s0_tok_reg;

    for (genvar gi = 0; gi < TAYLOR_TERMS; gi++)
    begin : g_taylor
        nau_taylor_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .divisor  (5'(gi + 1)),
            .up_valid (tay_valid[gi]),
            .up_tok   (tay_tok[gi]),
            .dn_valid (tay_valid[gi+1]),
            .dn_tok   (tay_tok[gi+1])
        );
    end

    always_comb
    begin
        pow_tok[0] = tay_tok[TAYLOR_TERMS];
        if (tay_tok[TAYLOR_TERMS].sum < 0)
        begin
            pow_tok[0].r = '0;
        end
        else if (tay_tok[TAYLOR_TERMS].sum > $signed({2'b00, Q_ONE}))
        begin
            pow_tok[0].r = Q_ONE;
        end
        else
        begin
            pow_tok[0].r = tay_tok[TAYLOR_TERMS].sum[30:0];
        end
    end

    assign pow_valid[0] = tay_valid[TAYLOR_TERMS];

    for (genvar gi = 0; gi < POW_STEPS; gi++)
    begin : g_pow
        nau_pow_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .step     (5'(gi)),
            .up_valid (pow_valid[gi]),
            .up_tok   (pow_tok[gi]),
            .dn_valid (pow_valid[gi+1]),
            .dn_tok   (pow_tok[gi+1])
        );
    end

    always_comb
    begin
        s1_tok_next = pow_tok[POW_STEPS];
        t_val       = pow_tok[POW_STEPS].zero ? 31'd0 : pow_tok[POW_STEPS].r;
        if (kind_reg == FN_SOFTPLUS && !deriv_reg)
        begin
            s1_tok_next.den = {1'b1, 31'd0} + 32'(t_val);
        end
        else
        begin
            s1_tok_next.den = 32'(Q_ONE) + 32'(t_val);
        end
        case (kind_reg)
            FN_SIGMOID:  num1 = (deriv_reg || pow_tok[POW_STEPS].neg) ? t_val : Q_ONE;
            FN_SOFTPLUS: num1 = (!deriv_reg || pow_tok[POW_STEPS].neg) ? t_val : Q_ONE;
            FN_TANH:     num1 = Q_ONE - t_val;
            default:     num1 = t_val;
        endcase
        hi1             = num1 + 31'(s1_tok_next.den[31]);
        s1_tok_next.r   = t_val;
        s1_tok_next.rem = {3'b000, hi1[30:1]};
        s1_tok_next.dlo = {hi1[0], s1_tok_next.den[30:1]};
        s1_tok_next.quo = '0;
    end

    assign d1_valid[0] = s1_valid_reg;
    assign d1_tok[0]   = s1_tok_reg;

    for (genvar gi = 0; gi < DIV_STEPS; gi++)
    begin : g_div1
        nau_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .up_valid (d1_valid[gi]),
            .up_tok   (d1_tok[gi]),
            .dn_valid (d1_valid[gi+1]),
            .dn_tok   (d1_tok[gi+1])
        );
    end

    always_comb
    begin
        s2_tok_next     = d1_tok[DIV_STEPS];
        s2_tok_next.q1  = d1_tok[DIV_STEPS].quo;
        s2_tok_next.sq  = mul_q30(d1_tok[DIV_STEPS].quo, d1_tok[DIV_STEPS].quo);
        s2_tok_next.lp  = d1_tok[DIV_STEPS].quo;
        s2_tok_next.ls  = d1_tok[DIV_STEPS].quo;
        hi2             = d1_tok[DIV_STEPS].quo + 31'(d1_tok[DIV_STEPS].den[31]);
        s2_tok_next.rem = {3'b000, hi2[30:1]};
        s2_tok_next.dlo = {hi2[0], d1_tok[DIV_STEPS].den[30:1]};
        s2_tok_next.quo = '0;
    end

    assign d2_valid[0] = s2_valid_reg;
    assign d2_tok[0]   = s2_tok_reg;

    for (genvar gi = 0; gi < DIV_STEPS; gi++)
    begin : g_div2
        nau_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .up_valid (d2_valid[gi]),
            .up_tok   (d2_tok[gi]),
            .dn_valid (d2_valid[gi+1]),
            .dn_tok   (d2_tok[gi+1])
        );
    end

    assign ln_valid[0] = d2_valid[DIV_STEPS];
    assign ln_tok[0]   = d2_tok[DIV_STEPS];

    for (genvar gi = 0; gi < LN_TERMS; gi++)
    begin : g_ln
        nau_ln_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .divisor  (5'(2 * gi + 3)),
            .up_valid (ln_valid[gi]),
            .up_tok   (ln_tok[gi]),
            .dn_valid (ln_valid[gi+1]),
            .dn_tok   (ln_tok[gi+1])
        );
    end

    always_comb
    begin
        fin   = ln_tok[LN_TERMS];
        x_ext = {{(SW - DATA_WIDTH){fin.x[DATA_WIDTH-1]}}, fin.x};
        case (kind_reg)
            FN_IDENTITY: y_full = deriv_reg ? ONE_Y : x_ext;
            FN_STEP:     y_full = (deriv_reg || fin.neg) ? '0 : ONE_Y;
            FN_SIGMOID:  y_full = from_q30(32'(deriv_reg ? fin.quo : fin.q1));
            FN_TANH:
            begin
                if (deriv_reg)
                begin
                    y_full = from_q30(32'(Q_ONE) - 32'(fin.sq));
                end
                else if (fin.neg)
                begin
                    y_full = -from_q30(32'(fin.q1));
                end
                else
                begin
                    y_full = from_q30(32'(fin.q1));
                end
            end
            FN_RELU:
            begin
                if (fin.neg)
                begin
                    y_full = '0;
                end
                else
                begin
                    y_full = deriv_reg ? ONE_Y : x_ext;
                end
            end
            FN_SOFTPLUS:
            begin
                if (deriv_reg)
                begin
                    y_full = from_q30(32'(fin.q1));
                end
                else
                begin
                    y_full = (fin.neg ? SW'(0) : x_ext) + from_q30({fin.ls, 1'b0});
                end
            end
            default:     y_full = '0;
        endcase
        if (y_full > SAT_HI)
        begin
            final_y = SAT_HI[DATA_WIDTH-1:0];
        end
        else if (y_full < SAT_LO)
        begin
            final_y = SAT_LO[DATA_WIDTH-1:0];
        end
        else
        begin
            final_y = y_full[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s0_valid_reg <= in_valid;
                s1_valid_reg <= pow_valid[POW_STEPS];
                s2_valid_reg <= d1_valid[DIV_STEPS];
            end
            if (skid_valid_reg)
            begin
                if (take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (!out_valid_reg || take)
            begin
                out_valid_reg <= pipe_valid;
            end
            else if (pipe_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_tok_reg <= s0_tok_next;
            s1_tok_reg <= s1_tok_next;
            s2_tok_reg <= s2_tok_next;
        end
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_y_reg <= skid_y_reg;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_y_reg <= final_y;
        end
        else if (pipe_valid)
        begin
            skid_y_reg <= final_y;
        end
    end

    `NAU_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid item without output item")
    `NAU_ASSERT_NEXT(a_skid_fill, out_valid_reg && out_stall && !skid_valid_reg && pipe_valid, skid_valid_reg, "result dropped while output stalled")

endmodule

@@ tb/tb_neural_activation_unit.sv @@
// ----------------------------------------------------------------------------
// Activation unit testbench
// Streams Q4.11 samples through every function and derivative setting, with
// random valid and stall bursts on both sides. Each result is checked against
// an in-bench fixed-point model of exp, ln, sigmoid, tanh and softplus.
// ----------------------------------------------------------------------------
module tb_neural_activation_unit;
    import nau_pkg::*;

    localparam logic [2:0] FN_SPARE_A = 3'd6;
    localparam logic [2:0] FN_SPARE_B = 3'd7;
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;
    localparam int PIPE_DRAIN = 170;
    localparam longint unsigned ONE_Q = 64'd1 << 30;
    localparam longint unsigned EXP_LIMIT = 64'd32 << 30;
    localparam longint unsigned EXP_M1_Q = 64'd395007542;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [2:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [DATA_WIDTH-1:0] x_in;
    logic out_valid;
    logic out_stall;
    logic signed [DATA_WIDTH-1:0] y_out;

    logic [2:0] kind_now;
    logic deriv_now;
    logic [DATA_WIDTH-1:0] pending_y [$];
    int errors;
    bit quiet;

    neural_activation_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .x_in(x_in),
        .out_valid(out_valid), .out_stall(out_stall), .y_out(y_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

    function automatic longint unsigned qmul(longint unsigned p, longint unsigned q);
        return (p * q + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint unsigned qdiv(longint unsigned n, longint unsigned d);
        if (d == 0)
            return 0;
        return ((n << 30) + d / 2) / d;
    endfunction

    function automatic longint unsigned exp_neg(longint unsigned v);
        longint unsigned n;
        longint unsigned f;
        longint unsigned term;
        longint unsigned r;
        longint sum;
        if (v >= EXP_LIMIT)
            return 0;
        n = v >> 30;
        f = v & (ONE_Q - 1);
        sum = longint'(ONE_Q);
        term = ONE_Q;
        for (int k = 1; k <= 14; k++)
        begin
            term = ((term * f) >> 30) / longint'(k);
            if (k % 2 == 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(ONE_Q))
            sum = longint'(ONE_Q);
        r = longint'(sum);
        for (longint unsigned i = 0; i < n; i++)
            r = qmul(r, EXP_M1_Q);
        return r;
    endfunction

    function automatic longint to_out(bit neg, longint unsigned mag);
        longint unsigned r;
        r = (mag + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] activation_of(logic signed [DATA_WIDTH-1:0] xs);
        longint x;
        longint y;
        longint one;
        longint hi;
        bit neg;
        longint unsigned a, aq, aq2, t, u, s, th, z, z2, p, acc;
        x = xs;
        one = longint'(1) << FRAC_BITS;
        neg = x < 0;
        a = neg ? -x : x;
        aq = ((a >> FRAC_BITS) >= 32) ? EXP_LIMIT : (a << (30 - FRAC_BITS));
        aq2 = (2 * aq > EXP_LIMIT) ? EXP_LIMIT : 2 * aq;
        y = 0;
        case (kind_now)
            FN_IDENTITY: y = deriv_now ? one : x;
            FN_STEP:     y = deriv_now ? 0 : (neg ? 0 : one);
            FN_SIGMOID:
            begin
                t = exp_neg(aq);
                if (deriv_now)
                begin
                    s = qdiv(t, ONE_Q + t);
                    y = to_out(0, qdiv(s, ONE_Q + t));
                end
                else
                    y = to_out(0, qdiv(neg ? t : ONE_Q, ONE_Q + t));
            end
            FN_TANH:
            begin
                u = exp_neg(aq2);
                th = qdiv(ONE_Q - u, ONE_Q + u);
                if (deriv_now)
                    y = to_out(0, ONE_Q - qmul(th, th));
                else
                    y = to_out(neg, th);
            end
            FN_RELU:     y = neg ? 0 : (deriv_now ? one : x);
            FN_SOFTPLUS:
            begin
                t = exp_neg(aq);
                if (deriv_now)
                    y = to_out(0, qdiv(neg ? t : ONE_Q, ONE_Q + t));
                else
                begin
                    z = qdiv(t, 2 * ONE_Q + t);
                    z2 = qmul(z, z);
                    p = z;
                    acc = z;
                    for (int k = 1; k <= 12; k++)
                    begin
                        p = qmul(p, z2);
                        acc += p / longint'(2 * k + 1);
                    end
                    y = (neg ? 0 : x) + to_out(0, 2 * acc);
                end
            end
            default:     y = 0;
        endcase
        hi = (longint'(1) << (DATA_WIDTH - 1)) - 1;
        if (y > hi)
            y = hi;
        if (y < -hi - 1)
            y = -hi - 1;
        return y[DATA_WIDTH-1:0];
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_y.size() == 0)
            begin
                $display("%0t: unexpected item y_out=%0d", $time, y_out);
                errors++;
            end
            else if (y_out !== pending_y[0])
            begin
                $display("%0t: y_out expected %0d actual %0d", $time,
                    $signed(pending_y[0]), y_out);
                errors++;
                void'(pending_y.pop_front());
            end
            else
                void'(pending_y.pop_front());
        end
    end

    int stall_left;
    always @(negedge clk)
    begin
        if (quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // call at a falling edge; returns at a falling edge
    task automatic send_sample(logic signed [DATA_WIDTH-1:0] xs);
        in_valid <= 1'b1;
        x_in <= xs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_y.push_back(activation_of(xs));
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_y.size() != 0)
            @(negedge clk);
        repeat (PIPE_DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [2:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FUNCTION_KIND)
            kind_now = val;
        else if (idx == REG_DERIVATIVE_MODE)
            deriv_now = val[0];
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] random_sample;
        case ($urandom_range(0, 3))
            0: return $signed(16'($urandom_range(0, 16'hffff)));
            1: return $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
            2: return $signed(16'($urandom_range(0, 4096))) - 16'sd2048;
            default: return $signed(16'($urandom_range(0, 65535)));
        endcase
    endfunction

    task automatic test_extremes;
        logic signed [DATA_WIDTH-1:0] edges [0:6];
        edges = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1, 16'sd1, 16'sd2048, -16'sd2048};
        for (int k = 0; k < 8; k++)
        begin
            for (int d = 0; d < 2; d++)
            begin
                write_reg(REG_FUNCTION_KIND, 3'(k));
                write_reg(REG_DERIVATIVE_MODE, 3'(d));
                foreach (edges[i])
                    send_sample(edges[i]);
            end
        end
    endtask

    task automatic test_register_decode;
        write_reg(REG_FUNCTION_KIND, FN_SIGMOID);
        write_reg(REG_DERIVATIVE_MODE, 3'b110);
        write_reg(REG_SPARE_A, FN_TANH);
        write_reg(REG_SPARE_B, 3'b111);
        send_sample(16'sd1000);
        send_sample(-16'sd1000);
        write_reg(REG_DERIVATIVE_MODE, 3'b111);
        send_sample(16'sd300);
        write_reg(REG_FUNCTION_KIND, FN_SPARE_B);
        send_sample(16'sd300);
        write_reg(REG_FUNCTION_KIND, FN_SPARE_A);
        send_sample(-16'sd300);
    endtask

    task automatic test_random_stream;
        for (int phase = 0; phase < 15; phase++)
        begin
            if (phase == 12)
                quiet = 1'b1;
            write_reg(REG_FUNCTION_KIND, 3'($urandom_range(0, 7)));
            write_reg(REG_DERIVATIVE_MODE, 3'($urandom_range(0, 7)));
            repeat (42)
                send_sample(random_sample());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        x_in = '0;
        out_stall = 1'b0;
        stall_left = 0;
        kind_now = FN_IDENTITY;
        deriv_now = 1'b0;
        errors = 0;
        quiet = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        send_sample(16'sd777);
        send_sample(-16'sd777);
        test_extremes();
        test_register_decode();
        test_random_stream();
        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/nau_pkg.sv
design/nau_taylor_cell.sv
design/nau_pow_cell.sv
design/nau_div_cell.sv
design/nau_ln_cell.sv
design/neural_activation_unit.sv
tb/tb_neural_activation_unit.sv
